// ===== hdl/tgp_pkg.sv =====
package tgp_pkg;

  // default geometry
  localparam int unsigned GlyphLinesDef = 15;
  localparam int unsigned ScanColsDef   = 1024;
  localparam int unsigned GlyphCountDef = 96;

  // register indexes
  localparam logic [1:0] CfgColorMode    = 2'd0;
  localparam logic [1:0] CfgReverseVideo = 2'd1;
  localparam logic [1:0] CfgFrameBase    = 2'd2;

  // request commands
  localparam logic CmdPaint = 1'b0;
  localparam logic CmdLoad  = 1'b1;

  localparam logic [6:0] CharSpace = 7'd32;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  char_code;
    logic [5:0]  text_row;
    logic [6:0]  text_col;
    logic [10:0] glyph_addr;
    logic [7:0]  glyph_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] write_addr;
    logic [31:0] word_lo;
    logic [31:0] word_hi;
    logic        is_color_write;
    logic        last;
  } res_t;

  // control of the shared address adder
  typedef struct packed {
    logic load;  // acc = base + operand
    logic add;   // acc = acc + operand
  } addr_ctrl_t;

  // one byte of 0 or 1 per nibble bit
  function automatic logic [31:0] nibble_spread(input logic [3:0] nib);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      w[8*i] = nib[i];
    end
    return w;
  endfunction

endpackage

// ===== hdl/tgp_glyph_mem.sv =====
module tgp_glyph_mem #(
  parameter int unsigned Depth = tgp_pkg::GlyphCountDef * tgp_pkg::GlyphLinesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tgp_addr_unit.sv =====
module tgp_addr_unit (
  input  logic                clk_i,
  input  tgp_pkg::addr_ctrl_t ctrl_i,
  input  logic [31:0]         base_i,
  input  logic [31:0]         operand_i,
  output logic [31:0]         acc_o
);

  logic [31:0] acc_q, acc_d, lhs;

  // one 32-bit adder, left side picked by the sequencer
  always_comb begin
    lhs   = ctrl_i.load ? base_i : acc_q;
    acc_d = acc_q;
    if (ctrl_i.load || ctrl_i.add) begin
      acc_d = lhs + operand_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/text_glyph_painter_core.sv =====
// Paint request: busy is high through the Setup, Row and Line states; a new request is
// accepted once busy falls. The first result strobe follows Setup, Row, the first Line
// state and the result register, then one result per cycle, GLYPH_LINES results in all,
// the final one flagged by last. Load request: no result, busy stays low.
// Reset (rst_ni, async, active low) clears the sequencer, line counter, strobe and
// config registers; the glyph store is undefined until loaded. Results cannot be stalled.
module text_glyph_painter_core #(
  parameter int unsigned GLYPH_LINES = tgp_pkg::GlyphLinesDef,
  parameter int unsigned SCAN_COLS   = tgp_pkg::ScanColsDef,
  parameter int unsigned GLYPH_COUNT = tgp_pkg::GlyphCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tgp_pkg::req_t req_i,
  output logic          res_valid_o,
  output tgp_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned StoreDepth = GLYPH_COUNT * GLYPH_LINES;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned LineW      = $clog2(GLYPH_LINES);
  localparam logic [LineW-1:0] LastLine = LineW'(GLYPH_LINES - 1);

  // scanline strides and text row strides, in bytes
  localparam logic [31:0] StrideMono = 32'(SCAN_COLS / 4);
  localparam logic [31:0] StrideCol  = 32'(SCAN_COLS);
  localparam logic [31:0] RowMono    = 32'(GLYPH_LINES * (SCAN_COLS / 4));
  localparam logic [31:0] RowCol     = 32'(GLYPH_LINES * SCAN_COLS);

  // sequencer codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;  // column term, glyph base, row product
  localparam logic [1:0] StRow   = 2'd2;  // add row term, read line 0
  localparam logic [1:0] StLine  = 2'd3;  // one scanline result per cycle

  logic [1:0] state_q, state_d;

  // configuration
  logic        color_q, rev_q;
  logic [31:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
      rev_q   <= 1'b0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgp_pkg::CfgColorMode:    color_q <= cfg_data_i[0];
        tgp_pkg::CfgReverseVideo: rev_q   <= cfg_data_i[0];
        tgp_pkg::CfgFrameBase:    base_q  <= cfg_data_i;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // request acceptance
  logic accept, paint_acc, load_acc, load_ok;

  assign busy      = (state_q != StIdle);
  assign accept    = start && !busy;
  assign paint_acc = accept && (req_i.cmd == tgp_pkg::CmdPaint);
  assign load_acc  = accept && (req_i.cmd == tgp_pkg::CmdLoad);
  // out-of-range load addresses are dropped
  assign load_ok   = load_acc && (32'(req_i.glyph_addr) < StoreDepth);

  // paint request latch
  logic [6:0] code_q;
  logic [5:0] row_q;
  logic [6:0] col_q;

  always_ff @(posedge clk_i) begin
    if (paint_acc) begin
      code_q <= req_i.char_code;
      row_q  <= req_i.text_row;
      col_q  <= req_i.text_col;
    end
  end

  // glyph index wraps in 7 bits; indices past the store read as zero
  logic [6:0]  glyph;
  logic [11:0] glyph_base;

  assign glyph      = code_q - tgp_pkg::CharSpace;
  assign glyph_base = 12'(glyph) * 12'(GLYPH_LINES);

  logic               glyph_ok_q, blank_q;
  logic [31:0]        row_term_q;
  logic [StoreAw-1:0] rdptr_q;
  logic [LineW-1:0]   line_q;

  // shared address adder control
  tgp_pkg::addr_ctrl_t actrl;
  logic [31:0]         operand, acc;

  always_comb begin
    actrl   = '0;
    operand = color_q ? StrideCol : StrideMono;
    unique case (state_q)
      StSetup: begin
        actrl.load = 1'b1;
        operand    = color_q ? {22'd0, col_q, 3'd0} : 32'(col_q);
      end
      StRow: begin
        actrl.add = 1'b1;
        operand   = row_term_q;
      end
      StLine: begin
        actrl.add = 1'b1;
      end
      default: ;
    endcase
  end

  tgp_addr_unit u_addr (
    .clk_i     (clk_i),
    .ctrl_i    (actrl),
    .base_i    (base_q),
    .operand_i (operand),
    .acc_o     (acc)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (paint_acc) state_d = StSetup;
      StSetup: state_d = StRow;
      StRow:   state_d = StLine;
      StLine:  if (line_q == LastLine) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (state_q == StRow) begin
      line_q <= '0;
    end else if (state_q == StLine) begin
      line_q <= line_q + LineW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSetup) begin
      glyph_ok_q <= (32'(glyph) < GLYPH_COUNT);
      blank_q    <= !color_q && !rev_q && (code_q == tgp_pkg::CharSpace);
      row_term_q <= 32'(row_q) * (color_q ? RowCol : RowMono);
      rdptr_q    <= glyph_base[StoreAw-1:0];
    end else if (state_q == StRow || state_q == StLine) begin
      rdptr_q <= rdptr_q + StoreAw'(1);
    end
  end

  // glyph store: read data is registered and lands in the cycle after the pointer
  logic [7:0] rdata;

  tgp_glyph_mem #(
    .Depth (StoreDepth),
    .AddrW (StoreAw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (StoreAw'(req_i.glyph_addr)),
    .wdata_i (req_i.glyph_byte),
    .raddr_i (rdptr_q),
    .rdata_o (rdata)
  );

  // scanline byte: zero past the store, inverted for reverse video, blank space
  logic [7:0] gbyte;

  always_comb begin
    gbyte = glyph_ok_q ? rdata : 8'h00;
    if (rev_q) gbyte = ~gbyte;
    if (blank_q) gbyte = 8'h00;
  end

  // result register
  logic          res_valid_q;
  tgp_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == StLine);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLine) begin
      res_q.write_addr     <= acc;
      res_q.is_color_write <= color_q;
      res_q.last           <= (line_q == LastLine);
      if (color_q) begin
        res_q.word_lo <= tgp_pkg::nibble_spread(gbyte[3:0]);
        res_q.word_hi <= tgp_pkg::nibble_spread(gbyte[7:4]);
      end else begin
        res_q.word_lo <= 32'(gbyte);
        res_q.word_hi <= '0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // the final scanline result coincides with the sequencer going idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> state_q == StIdle)
    else $error("last result while sequencer still busy");

  // a paint request always starts the setup step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    paint_acc |=> state_q == StSetup)
    else $error("paint request not started");

  // row step is followed directly by the first scanline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRow |=> state_q == StLine && line_q == '0)
    else $error("row step not followed by first scanline");

  // mono writes carry no high word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.is_color_write |-> res_o.word_hi == '0)
    else $error("mono result with non-zero high word");

  // results only follow scanline cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == StLine)
    else $error("result strobe without scanline step");
`endif

endmodule

// ===== tb/text_glyph_painter_core_tb.sv =====
`timescale 1ns / 100ps

module text_glyph_painter_core_tb;

  // geometry as built into the core by default
  localparam int unsigned Lines          = tgp_pkg::GlyphLinesDef;
  localparam int unsigned Glyphs         = tgp_pkg::GlyphCountDef;
  localparam int unsigned StoreSize      = Lines * Glyphs;
  localparam int unsigned MonoPitch      = tgp_pkg::ScanColsDef / 4;
  localparam int unsigned ColourPitch    = tgp_pkg::ScanColsDef;
  localparam int unsigned AddrSpan       = 2048;     // every 11-bit load address
  localparam int unsigned RandomPerBatch = 60;
  localparam int unsigned SettleCycles   = 24;       // longer than one paint's result sequence
  localparam int unsigned CycleLimit     = 200000;

  logic          clk_i      = 1'b0;
  logic          rst_ni     = 1'b0;
  logic          start      = 1'b0;
  logic          busy;
  tgp_pkg::req_t req_i      = '0;
  logic          res_valid_o;
  tgp_pkg::res_t res_o;
  logic          cfg_we_i   = 1'b0;
  logic [1:0]    cfg_idx_i  = tgp_pkg::CfgColorMode;
  logic [31:0]   cfg_data_i = '0;

  // shadow of the core: glyph store and register copies
  logic [7:0]  glyph_mem [StoreSize];
  logic        colour_on;
  logic        inverse_on;
  logic [31:0] fb_base;

  // stimulus side: which store bytes have been loaded so far (in request order)
  bit          byte_loaded [StoreSize];

  tgp_pkg::req_t req_backlog [$];   // requests waiting for the driver
  tgp_pkg::res_t writes_due [$];    // framebuffer writes the core still owes
  int unsigned   reqs_sent;
  int unsigned   reqs_taken;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  // driver pacing
  int unsigned gap_left;
  bit          gap_when_idle;     // count the gap only while busy is low
  bit          burst;             // back-to-back stretch, no gaps

  text_glyph_painter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Expected behaviour
  // ---------------------------------------------------------------------------

  // one byte of 0 or 1 per nibble bit, bit 0 in the lowest byte
  function automatic logic [31:0] bytes_of_nibble(input logic [3:0] nib);
    return {7'd0, nib[3], 7'd0, nib[2], 7'd0, nib[1], 7'd0, nib[0]};
  endfunction

  // Work out the scanline writes of a paint request under the current settings.
  function automatic void queue_glyph_writes(input tgp_pkg::req_t r);
    logic [6:0]    gidx;
    logic [31:0]   pitch;
    logic [31:0]   addr;
    logic [7:0]    bits;
    tgp_pkg::res_t w;
    gidx  = r.char_code - tgp_pkg::CharSpace;   // codes below a space wrap round in 7 bits
    pitch = colour_on ? ColourPitch : MonoPitch;
    addr  = fb_base + (colour_on ? {22'd0, r.text_col, 3'd0} : {25'd0, r.text_col});
    addr  = addr + 32'(r.text_row) * Lines * pitch;
    for (int j = 0; j < Lines; j++) begin
      // glyph indexes past the store read as blank
      bits = (gidx < Glyphs) ? glyph_mem[gidx * Lines + j] : 8'h00;
      if (inverse_on) begin
        bits = ~bits;
      end
      // mono space without reverse video is always blank
      if (!colour_on && !inverse_on && r.char_code == tgp_pkg::CharSpace) begin
        bits = 8'h00;
      end
      w.write_addr     = addr;
      w.word_lo        = colour_on ? bytes_of_nibble(bits[3:0]) : {24'd0, bits};
      w.word_hi        = colour_on ? bytes_of_nibble(bits[7:4]) : 32'd0;
      w.is_color_write = colour_on;
      w.last           = (j == Lines - 1);
      writes_due.push_back(w);
      addr = addr + pitch;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom);
  endfunction

  function automatic logic [5:0] pick_row();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 6'd63 : 6'd0;
    end
    return 6'($urandom);
  endfunction

  function automatic logic [6:0] pick_col();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 7'd127 : 7'd0;
    end
    return 7'($urandom);
  endfunction

  // paint fields of a load are don't-care, so they carry noise
  function automatic void push_load(input int unsigned a, input logic [7:0] b);
    tgp_pkg::req_t r;
    r.cmd        = tgp_pkg::CmdLoad;
    r.char_code  = 7'($urandom);
    r.text_row   = 6'($urandom);
    r.text_col   = 7'($urandom);
    r.glyph_addr = 11'(a);
    r.glyph_byte = b;
    if (a < StoreSize) begin
      byte_loaded[a] = 1'b1;
    end
    req_backlog.push_back(r);
    reqs_sent++;
  endfunction

  function automatic void push_paint(input logic [6:0] code, input logic [5:0] row,
                                     input logic [6:0] col);
    tgp_pkg::req_t r;
    r.cmd        = tgp_pkg::CmdPaint;
    r.char_code  = code;
    r.text_row   = row;
    r.text_col   = col;
    r.glyph_addr = 11'($urandom);
    r.glyph_byte = 8'($urandom);
    req_backlog.push_back(r);
    reqs_sent++;
  endfunction

  function automatic bit glyph_ready(input int unsigned g);
    for (int j = 0; j < Lines; j++) begin
      if (!byte_loaded[g * Lines + j]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Mostly paints of fully loaded glyphs, with whole-glyph reloads,
  // stray single-byte loads and loads past the end of the store mixed in.
  function automatic void random_requests(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned g;
    logic [6:0]  code;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        g = $urandom_range(0, Glyphs - 1);
        for (int j = 0; j < Lines; j++) begin
          push_load(g * Lines + j, pick_byte());
        end
        made += Lines;
      end else if (pick < 22) begin
        g = $urandom_range(0, AddrSpan - 1);
        push_load(g, pick_byte());
        if (g < StoreSize) begin
          made++;   // loads past the store are dropped by the core
        end
      end else begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          code = tgp_pkg::CharSpace;
        end else if (pick == 1) begin
          code = 7'($urandom_range(0, 31));   // wraps beyond the glyph set
        end else begin
          do begin
            code = 7'($urandom_range(33, 127));
          end while (!glyph_ready(code - tgp_pkg::CharSpace));
        end
        push_paint(code, pick_row(), pick_col());
        made++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing of the run
  // ---------------------------------------------------------------------------

  // wait until every request is taken and every write has come out
  task automatic settle();
    while (reqs_sent != reqs_taken || writes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      tgp_pkg::CfgColorMode: begin
        colour_on = val[0];
      end
      tgp_pkg::CfgReverseVideo: begin
        inverse_on = val[0];
      end
      tgp_pkg::CfgFrameBase: begin
        fb_base = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic colour, input logic inverse, input logic [31:0] base);
    set_reg(tgp_pkg::CfgColorMode, {31'd0, colour});
    set_reg(tgp_pkg::CfgReverseVideo, {31'd0, inverse});
    set_reg(tgp_pkg::CfgFrameBase, base);
  endtask

  // edge paints under each setting, then a random batch
  task automatic run_batch();
    push_paint(tgp_pkg::CharSpace, 6'd0, 7'd0);
    push_paint(7'd127, 6'd63, 7'd127);
    push_paint(7'd0, pick_row(), pick_col());
    push_paint(7'd31, pick_row(), pick_col());
    random_requests(RandomPerBatch);
    settle();
  endtask

  initial begin
    colour_on  = 1'b0;
    inverse_on = 1'b0;
    fb_base    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: load the space glyph and the top glyph (which ends at the last
    // store byte), byte values at both extremes, plus two loads past the store.
    for (int j = 0; j < Lines; j++) begin
      push_load(j, (j == 0) ? 8'hFF : (j == Lines - 1) ? 8'h00 : 8'(8'hA5 ^ j));
      push_load((Glyphs - 1) * Lines + j, 8'(j * 17));
    end
    push_load(StoreSize, 8'hFF);
    push_load(AddrSpan - 1, 8'h5A);
    push_paint(tgp_pkg::CharSpace, 6'd63, 7'd0);
    run_batch();                                   // reset settings

    configure(1'b0, 1'b1, 32'hFFFF_FFFF);          // mono, reverse, top base
    run_batch();
    configure(1'b1, 1'b0, 32'hFFFF_0000);          // colour, addresses wrap
    run_batch();
    configure(1'b1, 1'b1, $urandom);
    run_batch();
    configure(1'b0, 1'b0, $urandom);
    run_batch();
    configure(1'b1, 1'b0, 32'h0000_0000);
    run_batch();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: a request is taken at an edge where start is high and busy low.
  // Start is held while busy; random gaps between requests, counted
  // either on every cycle or only while busy is low, so start rises at all
  // points of a paint as well as after it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        if (req_i.cmd == tgp_pkg::CmdLoad) begin
          if (req_i.glyph_addr < StoreSize) begin
            glyph_mem[req_i.glyph_addr] = req_i.glyph_byte;
          end
        end else begin
          queue_glyph_writes(req_i);
        end
        reqs_taken++;
        gap_left      = burst ? 0 : $urandom_range(0, 9);
        gap_when_idle = $urandom_range(0, 1);
        if ($urandom_range(0, 31) == 0) begin
          burst = !burst;
        end
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          if (!gap_when_idle || !busy) begin
            gap_left--;
          end
          start <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req_i <= req_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobe is one write, checked against the oldest one due.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    tgp_pkg::res_t due;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (writes_due.size() == 0) begin
        note_mismatch($sformatf("write to %h with nothing due", res_o.write_addr));
      end else begin
        due = writes_due.pop_front();
        if (res_o.write_addr !== due.write_addr) begin
          note_mismatch($sformatf("write_addr %h, want %h", res_o.write_addr, due.write_addr));
        end
        if (res_o.word_lo !== due.word_lo) begin
          note_mismatch($sformatf("word_lo %h, want %h at %h", res_o.word_lo, due.word_lo,
                                  due.write_addr));
        end
        if (res_o.word_hi !== due.word_hi) begin
          note_mismatch($sformatf("word_hi %h, want %h at %h", res_o.word_hi, due.word_hi,
                                  due.write_addr));
        end
        if (res_o.is_color_write !== due.is_color_write) begin
          note_mismatch($sformatf("is_color_write %b, want %b at %h", res_o.is_color_write,
                                  due.is_color_write, due.write_addr));
        end
        if (res_o.last !== due.last) begin
          note_mismatch($sformatf("last %b, want %b at %h", res_o.last, due.last,
                                  due.write_addr));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/tgp_pkg.sv
hdl/tgp_glyph_mem.sv
hdl/tgp_addr_unit.sv
hdl/text_glyph_painter_core.sv
tb/text_glyph_painter_core_tb.sv
